[sv/bra_pkg.sv]
package bra_pkg;

  localparam int MAX_BITS_DEF   = 1024;
  localparam int WORD_WIDTH_DEF = 64;
  localparam int CHUNK          = 8;

  localparam int CAP_W = 11;
  localparam int POS_W = 10;
  localparam int LEN_W = 11;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SET   = 3'd2,
    CMD_TEST  = 3'd3,
    CMD_FIND  = 3'd4
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_ARG   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_MINIT,
    S_MARK,
    S_FIND,
    S_TEST,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic minit;
    logic mark;
    logic find;
    logic test_rd;
    logic not_found;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    cmd_e cmd;
    logic hit;
    logic last;
  } dp_sts_t;

endpackage

[sv/bra_datapath.sv]
module bra_datapath #(
  parameter int MAX_BITS   = bra_pkg::MAX_BITS_DEF,
  parameter int WORD_WIDTH = bra_pkg::WORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bra_pkg::CAP_W-1:0]  cap_i,
  input  logic [bra_pkg::CMD_W-1:0]  command_i,
  input  logic [bra_pkg::POS_W-1:0]  position_i,
  input  logic [bra_pkg::LEN_W-1:0]  length_i,
  input  logic                       polarity_i,
  input  bra_pkg::dp_cmd_t           cmd_i,
  output bra_pkg::dp_sts_t           sts_o,
  output logic [bra_pkg::ST_W-1:0]   status_o,
  output logic [bra_pkg::POS_W-1:0]  result_position_o,
  output logic                       bit_value_o,
  output logic [bra_pkg::CAP_W-1:0]  used_count_o
);
  import bra_pkg::*;

  localparam int NW   = (MAX_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
  localparam int IW   = $clog2(MAX_BITS);
  localparam int AW   = ((IW > 11) ? IW : 11) + 1;
  localparam int WLOG = $clog2(WORD_WIDTH);
  localparam int NWB  = (NW > 1) ? $clog2(NW) : 1;
  localparam int TW   = $clog2(MAX_BITS + 1);
  localparam int OW   = $clog2(CHUNK + 1);

  logic [WORD_WIDTH-1:0] map_q [NW];
  logic [AW-1:0]   ptr_q, end_q, len_q, run_q, start_q;
  logic            pol_q, mval_q, bval_q;
  logic [TW-1:0]   total_q;
  status_e         st_q;
  logic [POS_W-1:0] rpos_q;

  logic [AW-1:0]   cap_raw, cap_w, posx, pos_end, base, nxt, lim, k, run, st, hpos;
  logic [NWB-1:0]  wi;
  logic [WLOG-1:0] boff;
  logic [WORD_WIDTH-1:0] rd_word, wr_word;
  logic [CHUNK-1:0] chunk, newc;
  logic            hit, bad;
  logic [OW-1:0]   ones;
  cmd_e            in_cmd;

  assign in_cmd  = cmd_e'(command_i);
  assign cap_raw = AW'(cap_i);
  assign cap_w   = (cap_raw > AW'(MAX_BITS)) ? AW'(MAX_BITS) : cap_raw;
  assign posx    = AW'(position_i);
  assign pos_end = posx + AW'(length_i);

  always_comb begin
    case (in_cmd)
      CMD_ALLOC: bad = (length_i == '0) || (pos_end > cap_w);
      CMD_FREE:  bad = (posx >= cap_w) || (length_i == '0) || (pos_end > cap_w);
      CMD_SET:   bad = (posx >= cap_w);
      CMD_TEST:  bad = (posx >= cap_w);
      CMD_FIND:  bad = 1'b0;
      default:   bad = 1'b1;
    endcase
  end

  // one aligned chunk of the bitmap is visited per cycle
  assign wi      = ptr_q[WLOG +: NWB];
  assign boff    = ptr_q[WLOG-1:0] & ~WLOG'(CHUNK - 1);
  assign rd_word = map_q[wi];
  assign chunk   = CHUNK'(rd_word >> boff);
  assign base    = ptr_q & ~AW'(CHUNK - 1);
  assign nxt     = base + AW'(CHUNK);
  assign lim     = cmd_i.mark ? end_q : cap_w;
  assign wr_word = (rd_word & ~(WORD_WIDTH'({CHUNK{1'b1}}) << boff))
                 | (WORD_WIDTH'(newc) << boff);

  always_comb begin
    run  = run_q;
    st   = start_q;
    hit  = 1'b0;
    hpos = '0;
    newc = chunk;
    ones = '0;
    k    = '0;
    for (int j = 0; j < CHUNK; j++) begin
      k = base + AW'(j);
      if (k >= ptr_q && k < lim && !hit) begin
        if (cmd_i.find) begin
          if (chunk[j] == pol_q) begin
            hit  = 1'b1;
            hpos = k;
          end
        end else if (cmd_i.mark) begin
          if (chunk[j] != mval_q) ones = ones + OW'(1);
          newc[j] = mval_q;
        end else begin
          if (!chunk[j]) begin
            if (run == '0) st = k;
            run = run + AW'(1);
            if (run == len_q) hit = 1'b1;
          end else begin
            run = '0;
          end
        end
      end
    end
  end

  assign sts_o.bad  = bad;
  assign sts_o.cmd  = in_cmd;
  assign sts_o.hit  = hit;
  assign sts_o.last = (nxt >= lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NW; w++) map_q[w] <= '0;
      total_q <= '0;
      ptr_q   <= '0;
      end_q   <= '0;
      len_q   <= '0;
      run_q   <= '0;
      start_q <= '0;
      pol_q   <= 1'b0;
      mval_q  <= 1'b0;
      bval_q  <= 1'b0;
      st_q    <= ST_OK;
      rpos_q  <= '0;
      status_o          <= '0;
      result_position_o <= '0;
      bit_value_o       <= 1'b0;
      used_count_o      <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q  <= (in_cmd == CMD_FIND) ? '0 : posx;
        len_q  <= AW'(length_i);
        pol_q  <= polarity_i;
        run_q  <= '0;
        mval_q <= (in_cmd != CMD_FREE);
        end_q  <= (in_cmd == CMD_SET) ? posx + AW'(1) : pos_end;
        rpos_q <= '0;
        bval_q <= 1'b0;
        st_q   <= bad ? ST_BAD_ARG : ((in_cmd == CMD_FIND) ? ST_NOT_FOUND : ST_OK);
      end
      if (cmd_i.scan) begin
        run_q   <= run;
        start_q <= st;
        ptr_q   <= nxt;
      end
      if (cmd_i.minit) begin
        ptr_q  <= start_q;
        end_q  <= start_q + len_q;
        rpos_q <= POS_W'(start_q);
      end
      if (cmd_i.mark) begin
        map_q[wi] <= wr_word;
        total_q   <= mval_q ? total_q + TW'(ones) : total_q - TW'(ones);
        ptr_q     <= nxt;
      end
      if (cmd_i.find) begin
        ptr_q <= nxt;
        if (hit) begin
          st_q   <= ST_OK;
          rpos_q <= POS_W'(hpos);
        end
      end
      if (cmd_i.test_rd) bval_q <= rd_word[ptr_q[WLOG-1:0]];
      if (cmd_i.not_found) st_q <= ST_NOT_FOUND;
      if (cmd_i.emit) begin
        status_o          <= st_q;
        result_position_o <= rpos_q;
        bit_value_o       <= bval_q;
        used_count_o      <= CAP_W'(total_q);
      end
    end
  end

endmodule

[sv/bra_ctrl.sv]
module bra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  bra_pkg::dp_sts_t  sts_i,
  output bra_pkg::dp_cmd_t  cmd_o
);
  import bra_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ov_d       = ov_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.bad) begin
            state_d = S_RESP;
          end else begin
            case (sts_i.cmd)
              CMD_ALLOC: state_d = S_ALLOC;
              CMD_FREE:  state_d = S_MARK;
              CMD_SET:   state_d = S_MARK;
              CMD_TEST:  state_d = S_TEST;
              CMD_FIND:  state_d = S_FIND;
              default:   state_d = S_RESP;
            endcase
          end
        end
      end
      S_ALLOC: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          state_d = S_MINIT;
        end else if (sts_i.last) begin
          cmd_o.not_found = 1'b1;
          state_d = S_RESP;
        end
      end
      S_MINIT: begin
        cmd_o.minit = 1'b1;
        state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.last) state_d = S_RESP;
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        if (sts_i.hit || sts_i.last) state_d = S_RESP;
      end
      S_TEST: begin
        cmd_o.test_rd = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[sv/bitmap_run_allocator_core.sv]
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: position, length, polarity
//                                                 tuser: command
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: status, result_position,
//                                                 bit_value, used_count
// apb       in   psel/penable/pwrite, pready=1    reg 0: capacity_bits
//
// The bitmap is walked eight slots per cycle. Set and free mark their slots chunk by
// chunk; test reads the bit in a test state; alloc scans chunks for a free run,
// then marks it chunk by chunk; find-first scans until a hit or the end. Each then
// goes to the response state. Reset clears the bitmap and count at once, no sweep.
// A request is taken only in idle; a finished result waits in the output register
// while the next request is taken and worked on.
module bitmap_run_allocator_core #(
  parameter int MAX_BITS   = bra_pkg::MAX_BITS_DEF,
  parameter int WORD_WIDTH = bra_pkg::WORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // position[9:0], length[20:10], polarity[21]
  input  logic [2:0]  s_axis_tuser_i,  // command[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // status[1:0], result_position[11:2],
                                       // bit_value[12], used_count[23:13]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bra_pkg::*;

  localparam logic [2:0] ADDR_CAP = 3'd0;

  logic [CAP_W-1:0] capacity_q;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] rpos;
  logic             bval;
  logic [CAP_W-1:0] used;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAP) ? 32'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAP) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  bra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bra_datapath #(
    .MAX_BITS   (MAX_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cap_i             (capacity_q),
    .command_i         (s_axis_tuser_i),
    .position_i        (s_axis_tdata_i[9:0]),
    .length_i          (s_axis_tdata_i[20:10]),
    .polarity_i        (s_axis_tdata_i[21]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status),
    .result_position_o (rpos),
    .bit_value_o       (bval),
    .used_count_o      (used)
  );

  assign m_axis_tdata_o = {used, bval, rpos, status};

endmodule
